[src/tvsd_pkg.sv]
package tvsd_pkg;

  // tag byte codes
  localparam logic [7:0] TAG_UINT_LAST  = 8'd3;
  localparam logic [7:0] TAG_STR_FIRST  = 8'd4;
  localparam logic [7:0] TAG_STR_LAST   = 8'd6;
  localparam logic [7:0] TAG_VEC        = 8'd7;
  localparam logic [7:0] TAG_MAP        = 8'd8;
  localparam logic [7:0] TAG_EXT        = 8'd9;
  localparam logic [7:0] TAG_FLOAT      = 8'd10;
  localparam logic [7:0] TAG_BOOL       = 8'd11;
  localparam logic [7:0] TAG_NULL       = 8'd12;
  localparam logic [7:0] TAG_SINT_FIRST = 8'd13;
  localparam logic [7:0] TAG_SINT_LAST  = 8'd16;
  localparam logic [7:0] TAG_LIMIT      = 8'd17;

  // count fields of vectors and maps are always four bytes
  localparam logic [3:0] COUNT_BYTES = 4'd4;
  localparam logic [3:0] FLOAT_BYTES = 4'd8;
  localparam logic [3:0] BOOL_BYTES  = 4'd1;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_FIELD,
    PH_STRLEN,
    PH_STRBYTES,
    PH_COUNT,
    PH_KEYLEN,
    PH_KEYBYTES
  } phase_t;

  typedef enum logic [3:0] {
    KIND_UINT,
    KIND_SINT,
    KIND_FLOAT,
    KIND_BOOL,
    KIND_NULL,
    KIND_EXT,
    KIND_STRHDR,
    KIND_STRBYTE,
    KIND_VECHDR,
    KIND_MAPHDR,
    KIND_KEYHDR,
    KIND_KEYBYTE,
    KIND_UNKNOWN
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_TRUNCATED,
    ERR_OVERFLOW
  } err_t;

  // level stack operations
  typedef enum logic [1:0] {
    STK_HOLD,
    STK_FINISH,
    STK_PUSH,
    STK_CLEAR
  } stk_op_t;

  typedef struct packed {
    stk_op_t     op;
    logic [31:0] count;
    logic        is_map;
  } stk_cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic [4:0]  depth;
    logic [4:0]  closed;
    err_t        err;
  } tok_t;

  // 1, 2, 4 or 8 bytes from a two-bit size code
  function automatic logic [3:0] field_size(logic [1:0] code);
    return 4'd1 << code;
  endfunction

  // sign extension of a 1, 2, 4 or 8 byte big-endian value
  function automatic logic [63:0] sign_ext(logic [63:0] v, logic [1:0] code);
    logic [63:0] r;
    unique case (code)
      2'd0: r = {{56{v[7]}}, v[7:0]};
      2'd1: r = {{48{v[15]}}, v[15:0]};
      2'd2: r = {{32{v[31]}}, v[31:0]};
      2'd3: r = v;
    endcase
    return r;
  endfunction

endpackage

[src/tvsd_level_stack.sv]
module tvsd_level_stack #(
  parameter int MAX_DEPTH = 16,
  localparam int SPW = $clog2(MAX_DEPTH + 1),
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tvsd_pkg::stk_cmd_t cmd,
  output logic [SPW-1:0]     sp,
  output logic [SPW-1:0]     fin_closed,
  output logic [SPW-1:0]     fin_sp,
  output logic               fin_is_map,
  output logic               top_last
);
  import tvsd_pkg::*;

  logic [31:0]          items_r [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] map_r;
  logic [SPW-1:0]       sp_r;
  logic [MAX_DEPTH-1:0] last_w;
  logic                 found_w;
  logic [IW-1:0]        land_w;
  logic [SPW-1:0]       sp_dec_w;

  // per-level flag: the next finished element closes this level
  always_comb begin
    for (int l = 0; l < MAX_DEPTH; l++) begin
      last_w[l] = (items_r[l] <= 32'd1);
    end
  end

  // highest open level that stays open takes the count
  always_comb begin
    found_w = 1'b0;
    land_w  = '0;
    for (int l = 0; l < MAX_DEPTH; l++) begin
      if (SPW'(l) < sp_r && !last_w[l]) begin
        found_w = 1'b1;
        land_w  = IW'(l);
      end
    end
  end

  assign sp_dec_w   = sp_r - SPW'(1);
  assign fin_sp     = found_w ? (SPW'(land_w) + SPW'(1)) : '0;
  assign fin_closed = sp_r - fin_sp;
  assign fin_is_map = found_w & map_r[land_w];
  assign top_last   = (sp_r != '0) & last_w[sp_dec_w[IW-1:0]];
  assign sp         = sp_r;

  // stack pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      unique case (cmd.op)
        STK_FINISH: sp_r <= fin_sp;
        STK_PUSH:   sp_r <= sp_r + SPW'(1);
        STK_CLEAR:  sp_r <= '0;
        STK_HOLD:   sp_r <= sp_r;
      endcase
    end
  end

  // level contents, written on push and counted down on finish
  always_ff @(posedge clk) begin
    if (cmd.op == STK_FINISH && found_w) begin
      items_r[land_w] <= items_r[land_w] - 32'd1;
    end
    if (cmd.op == STK_PUSH) begin
      items_r[sp_r[IW-1:0]] <= cmd.count;
      map_r[sp_r[IW-1:0]]   <= cmd.is_map;
    end
  end

endmodule

[src/tagged_value_stream_decoder.sv]
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   data_byte, end_of_data
// out_      output     out_valid / out_stall token_kind, token_value, nesting_depth,
//                                            closed_levels, error_code
//
// one byte is taken every cycle while in_stall is low; its token, if any, is registered into the output buffer
// parse state and the level stack update in the cycle the byte is taken; the closing
// cascade comes from a priority search over the per-level last-item flags
// a two-entry output buffer holds results; in_stall rises only when both entries are full
// synchronous reset clears parse state and stack pointer; level contents are not reset
module tagged_value_stream_decoder #(
  parameter int MAX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [63:0] out_token_value,
  output logic [4:0]  out_nesting_depth,
  output logic [4:0]  out_closed_levels,
  output logic [1:0]  out_error_code
);
  import tvsd_pkg::*;

  localparam int SPW = $clog2(MAX_DEPTH + 1);

  phase_t      phase_r;
  logic [4:0]  tag_r;
  logic [3:0]  cnt_r;
  logic [63:0] acc_r;
  logic [31:0] sbl_r;

  logic [SPW-1:0] sp_w;
  logic [SPW-1:0] fin_closed_w;
  logic [SPW-1:0] fin_sp_w;
  logic           fin_is_map_w;
  logic           top_last_w;
  stk_cmd_t       stk_cmd;

  logic        in_acc;
  logic [7:0]  tag8_w;
  logic [63:0] acc_shift_w;
  logic [3:0]  cnt_dec_w;
  logic [31:0] sbl_dec_w;

  logic        emit_w;
  kind_t       kind_w;
  logic [63:0] value_w;
  logic        fin_w;
  logic        key_done_w;
  logic        push_w;
  logic        push_map_w;
  logic        overflow_w;
  logic        clr_w;
  phase_t      phase_base_w;
  logic [4:0]  tag_nxt;
  logic [3:0]  cnt_nxt;
  logic [63:0] acc_nxt;
  logic [31:0] sbl_nxt;

  phase_t         phase_after_w;
  logic [SPW-1:0] sp_after_w;
  err_t           err_w;
  phase_t         phase_nxt;

  logic tok_emit_w;
  tok_t tok_w;

  logic out_valid_r;
  logic skid_valid_r;
  tok_t main_r;
  tok_t skid_r;
  logic pop_w;

  assign in_acc      = in_valid && !in_stall;
  assign tag8_w      = {3'b000, tag_r};
  assign acc_shift_w = {acc_r[55:0], in_data_byte};
  assign cnt_dec_w   = (cnt_r != 4'd0) ? (cnt_r - 4'd1) : 4'd0;
  assign sbl_dec_w   = (sbl_r != 32'd0) ? (sbl_r - 32'd1) : 32'd0;

  tvsd_level_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (stk_cmd),
    .sp         (sp_w),
    .fin_closed (fin_closed_w),
    .fin_sp     (fin_sp_w),
    .fin_is_map (fin_is_map_w),
    .top_last   (top_last_w)
  );

  // byte decode: raw token and field datapath
  always_comb begin
    emit_w       = 1'b0;
    kind_w       = KIND_UINT;
    value_w      = '0;
    fin_w        = 1'b0;
    key_done_w   = 1'b0;
    push_w       = 1'b0;
    push_map_w   = 1'b0;
    overflow_w   = 1'b0;
    clr_w        = 1'b0;
    phase_base_w = phase_r;
    tag_nxt      = tag_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    sbl_nxt      = sbl_r;
    unique case (phase_r)
      PH_TAG: begin
        acc_nxt = '0;
        if (in_data_byte >= TAG_LIMIT) begin
          tag_nxt = '0;
          emit_w  = 1'b1;
          kind_w  = KIND_UNKNOWN;
          value_w = {56'd0, in_data_byte};
          fin_w   = 1'b1;
        end else begin
          tag_nxt = in_data_byte[4:0];
          priority if (in_data_byte <= TAG_UINT_LAST) begin
            phase_base_w = PH_FIELD;
            cnt_nxt      = field_size(in_data_byte[1:0]);
          end else if (in_data_byte >= TAG_SINT_FIRST) begin
            phase_base_w = PH_FIELD;
            cnt_nxt      = field_size(2'(in_data_byte - TAG_SINT_FIRST));
          end else if (in_data_byte <= TAG_STR_LAST) begin
            phase_base_w = PH_STRLEN;
            cnt_nxt      = field_size(2'(in_data_byte - TAG_STR_FIRST));
          end else if (in_data_byte <= TAG_MAP) begin
            phase_base_w = PH_COUNT;
            cnt_nxt      = COUNT_BYTES;
          end else if (in_data_byte == TAG_EXT) begin
            emit_w = 1'b1;
            kind_w = KIND_EXT;
            fin_w  = 1'b1;
          end else if (in_data_byte == TAG_FLOAT) begin
            phase_base_w = PH_FIELD;
            cnt_nxt      = FLOAT_BYTES;
          end else if (in_data_byte == TAG_BOOL) begin
            phase_base_w = PH_FIELD;
            cnt_nxt      = BOOL_BYTES;
          end else begin
            emit_w = 1'b1;
            kind_w = KIND_NULL;
            fin_w  = 1'b1;
          end
        end
      end
      PH_FIELD: begin
        acc_nxt = acc_shift_w;
        cnt_nxt = cnt_dec_w;
        if (cnt_dec_w == 4'd0) begin
          emit_w = 1'b1;
          fin_w  = 1'b1;
          priority if (tag8_w <= TAG_UINT_LAST) begin
            kind_w  = KIND_UINT;
            value_w = acc_shift_w;
          end else if (tag8_w >= TAG_SINT_FIRST && tag8_w <= TAG_SINT_LAST) begin
            kind_w  = KIND_SINT;
            value_w = sign_ext(acc_shift_w, 2'(tag8_w - TAG_SINT_FIRST));
          end else if (tag8_w == TAG_FLOAT) begin
            kind_w  = KIND_FLOAT;
            value_w = acc_shift_w;
          end else begin
            kind_w  = KIND_BOOL;
            value_w = {63'd0, (acc_shift_w[7:0] == 8'd1)};
          end
        end
      end
      PH_STRLEN: begin
        acc_nxt = acc_shift_w;
        cnt_nxt = cnt_dec_w;
        if (cnt_dec_w == 4'd0) begin
          emit_w  = 1'b1;
          kind_w  = KIND_STRHDR;
          value_w = {32'd0, acc_shift_w[31:0]};
          if (acc_shift_w[31:0] == 32'd0) begin
            fin_w = 1'b1;
          end else begin
            sbl_nxt      = acc_shift_w[31:0];
            phase_base_w = PH_STRBYTES;
          end
        end
      end
      PH_STRBYTES: begin
        emit_w  = 1'b1;
        kind_w  = KIND_STRBYTE;
        value_w = {56'd0, in_data_byte};
        sbl_nxt = sbl_dec_w;
        fin_w   = (sbl_dec_w == 32'd0);
      end
      PH_COUNT: begin
        acc_nxt = acc_shift_w;
        cnt_nxt = cnt_dec_w;
        if (cnt_dec_w == 4'd0) begin
          push_map_w = (tag8_w == TAG_MAP);
          emit_w     = 1'b1;
          kind_w     = push_map_w ? KIND_MAPHDR : KIND_VECHDR;
          value_w    = {32'd0, acc_shift_w[31:0]};
          if (acc_shift_w[31:0] == 32'd0) begin
            fin_w = 1'b1;
          end else if (sp_w >= SPW'(MAX_DEPTH)) begin
            overflow_w = 1'b1;
          end else begin
            push_w       = 1'b1;
            phase_base_w = push_map_w ? PH_KEYLEN : PH_TAG;
          end
        end
      end
      PH_KEYLEN: begin
        emit_w  = 1'b1;
        kind_w  = KIND_KEYHDR;
        value_w = {56'd0, in_data_byte};
        if (in_data_byte == 8'd0) begin
          key_done_w = 1'b1;
        end else begin
          sbl_nxt      = {24'd0, in_data_byte};
          phase_base_w = PH_KEYBYTES;
        end
      end
      PH_KEYBYTES: begin
        emit_w     = 1'b1;
        kind_w     = KIND_KEYBYTE;
        value_w    = {56'd0, in_data_byte};
        sbl_nxt    = sbl_dec_w;
        key_done_w = (sbl_dec_w == 32'd0);
      end
      default: begin
        clr_w        = 1'b1;
        phase_base_w = PH_TAG;
      end
    endcase
    // key finished: a value follows, unless the data ends on the last entry's key
    if (key_done_w) begin
      phase_base_w = PH_TAG;
      if (in_end_of_data && top_last_w) begin
        fin_w = 1'b1;
      end
    end
  end

  // next parse phase and error flag
  always_comb begin
    if (fin_w) begin
      sp_after_w    = fin_sp_w;
      phase_after_w = (fin_sp_w != '0 && fin_is_map_w) ? PH_KEYLEN : PH_TAG;
    end else begin
      sp_after_w    = push_w ? (sp_w + SPW'(1)) : (clr_w ? '0 : sp_w);
      phase_after_w = phase_base_w;
    end
    priority if (overflow_w) begin
      err_w = ERR_OVERFLOW;
    end else if (in_end_of_data && !(phase_after_w == PH_TAG && sp_after_w == '0)) begin
      err_w = ERR_TRUNCATED;
    end else begin
      err_w = ERR_NONE;
    end
    phase_nxt = (err_w != ERR_NONE || clr_w) ? PH_TAG : phase_after_w;
  end

  // result token and stack command
  always_comb begin
    tok_emit_w   = emit_w || (err_w != ERR_NONE);
    tok_w.kind   = emit_w ? kind_w : KIND_UINT;
    tok_w.value  = emit_w ? value_w : 64'd0;
    tok_w.depth  = 5'(sp_w);
    tok_w.closed = (emit_w && fin_w) ? 5'(fin_closed_w) : 5'd0;
    tok_w.err    = err_w;
    stk_cmd.count  = acc_shift_w[31:0];
    stk_cmd.is_map = push_map_w;
    priority if (!in_acc) begin
      stk_cmd.op = STK_HOLD;
    end else if (err_w != ERR_NONE || clr_w) begin
      stk_cmd.op = STK_CLEAR;
    end else if (fin_w) begin
      stk_cmd.op = STK_FINISH;
    end else if (push_w) begin
      stk_cmd.op = STK_PUSH;
    end else begin
      stk_cmd.op = STK_HOLD;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      tag_r   <= '0;
      cnt_r   <= '0;
      acc_r   <= '0;
      sbl_r   <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      if (err_w != ERR_NONE || clr_w) begin
        tag_r <= '0;
        cnt_r <= '0;
        acc_r <= '0;
        sbl_r <= '0;
      end else begin
        tag_r <= tag_nxt;
        cnt_r <= cnt_nxt;
        acc_r <= acc_nxt;
        sbl_r <= sbl_nxt;
      end
    end
  end

  // two-entry output buffer
  assign pop_w    = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop_w) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop_w) begin
      out_valid_r <= in_acc && tok_emit_w;
    end else if (in_acc && tok_emit_w) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop_w) begin
        main_r <= skid_r;
      end
    end else if (!out_valid_r || pop_w) begin
      main_r <= tok_w;
    end else begin
      skid_r <= tok_w;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_token_kind    = main_r.kind;
  assign out_token_value   = main_r.value;
  assign out_nesting_depth = main_r.depth;
  assign out_closed_levels = main_r.closed;
  assign out_error_code    = main_r.err;

  // buffer order: the second entry is only used behind a full first one
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("output buffer second entry held without first");

  // the last byte of the data always leaves the parser at a top-level tag
  a_end_returns_to_top: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_data) |=> (phase_r == PH_TAG && sp_w == '0))
    else $error("parser not at top level after end of data");

  // an overflow is only flagged with every level open
  a_overflow_full_stack: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && err_w == ERR_OVERFLOW) |-> (sp_w == SPW'(MAX_DEPTH)))
    else $error("nesting overflow flagged with free levels");

  // a stalled result is kept
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(main_r)))
    else $error("stalled result changed");

endmodule

[verif/tagged_value_stream_decoder_tb.sv]
module tagged_value_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tvsd_pkg::*;

  localparam int LEVELS      = 16;
  localparam int CYCLE_LIMIT = 250000;
  localparam int RAND_BYTES  = 800;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    bit         known;
    tok_t       tok;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_data = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_token_kind;
  logic [63:0] out_token_value;
  logic [4:0]  out_nesting_depth;
  logic [4:0]  out_closed_levels;
  logic [1:0]  out_error_code;

  // decoder state as predicted
  phase_t      ps;
  logic [4:0]  ptag;
  logic [3:0]  pcnt;
  logic [63:0] pacc;
  logic [31:0] pstr;
  logic [31:0] plev_left [LEVELS];
  bit          plev_map [LEVELS];
  int          psp;

  tok_t        pending_tokens [$];
  byte_item_t  seq_q [$];
  dir_row_t    dir_rows [$];

  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int tokens_seen = 0;
  int trunc_seen = 0;
  int overflow_seen = 0;
  int deepest_close = 0;

  tagged_value_stream_decoder #(.MAX_DEPTH(LEVELS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_data   (in_end_of_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_value  (out_token_value),
    .out_nesting_depth(out_nesting_depth),
    .out_closed_levels(out_closed_levels),
    .out_error_code   (out_error_code)
  );

  always #5 clk = ~clk;

  // back to a top-level tag with the stack emptied
  function automatic void reset_model();
    ps   = PH_TAG;
    ptag = '0;
    pcnt = '0;
    pacc = '0;
    pstr = '0;
    psp  = 0;
  endfunction

  // one element done: count it and pop every level that runs out
  function automatic int close_done_levels();
    int closed;
    int t;
    closed = 0;
    while (psp != 0) begin
      t = psp - 1;
      if (plev_left[t] != 0) plev_left[t] = plev_left[t] - 1;
      if (plev_left[t] != 0) break;
      psp--;
      closed++;
    end
    ps = (psp != 0 && plev_map[psp - 1]) ? PH_KEYLEN : PH_TAG;
    return closed;
  endfunction

  // token caused by one accepted byte, if any
  function automatic bit predict_token(input logic [7:0] b, input logic e, output tok_t tk);
    bit          emit;
    bit          key_done;
    bit          is_map;
    kind_t       kind;
    err_t        err;
    logic [63:0] val;
    logic [63:0] mask;
    logic [7:0]  rel;
    int          closed;
    int          depth;
    int          nb;
    emit     = 1'b0;
    key_done = 1'b0;
    kind     = KIND_UINT;
    err      = ERR_NONE;
    val      = '0;
    closed   = 0;
    depth    = psp;
    case (ps)
      PH_TAG: begin
        pacc = '0;
        if (b >= TAG_LIMIT) begin
          ptag   = '0;
          emit   = 1'b1;
          kind   = KIND_UNKNOWN;
          val    = {56'b0, b};
          closed = close_done_levels();
        end else begin
          ptag = b[4:0];
          if (b <= TAG_UINT_LAST) begin
            ps   = PH_FIELD;
            pcnt = 4'd1 << b[1:0];
          end else if (b >= TAG_SINT_FIRST) begin
            rel  = b - TAG_SINT_FIRST;
            ps   = PH_FIELD;
            pcnt = 4'd1 << rel[1:0];
          end else if (b <= TAG_STR_LAST) begin
            rel  = b - TAG_STR_FIRST;
            ps   = PH_STRLEN;
            pcnt = 4'd1 << rel[1:0];
          end else if (b == TAG_VEC || b == TAG_MAP) begin
            ps   = PH_COUNT;
            pcnt = COUNT_BYTES;
          end else if (b == TAG_EXT) begin
            emit   = 1'b1;
            kind   = KIND_EXT;
            closed = close_done_levels();
          end else if (b == TAG_FLOAT) begin
            ps   = PH_FIELD;
            pcnt = FLOAT_BYTES;
          end else if (b == TAG_BOOL) begin
            ps   = PH_FIELD;
            pcnt = BOOL_BYTES;
          end else begin
            emit   = 1'b1;
            kind   = KIND_NULL;
            closed = close_done_levels();
          end
        end
      end
      PH_FIELD: begin
        pacc = {pacc[55:0], b};
        if (pcnt != 0) pcnt = pcnt - 1'b1;
        if (pcnt == 0) begin
          emit = 1'b1;
          if ({3'b0, ptag} <= TAG_UINT_LAST) begin
            kind = KIND_UINT;
            val  = pacc;
          end else if ({3'b0, ptag} >= TAG_SINT_FIRST && {3'b0, ptag} <= TAG_SINT_LAST) begin
            // sign-extend from the field width
            rel  = {3'b0, ptag} - TAG_SINT_FIRST;
            nb   = 1 << rel[1:0];
            kind = KIND_SINT;
            val  = pacc;
            if (nb < 8) begin
              mask = (64'd1 << (nb * 8)) - 64'd1;
              val  = pacc & mask;
              if (val[nb * 8 - 1]) val = val | ~mask;
            end
          end else if ({3'b0, ptag} == TAG_FLOAT) begin
            kind = KIND_FLOAT;
            val  = pacc;
          end else begin
            kind = KIND_BOOL;
            val  = (pacc[7:0] == 8'd1) ? 64'd1 : 64'd0;
          end
          closed = close_done_levels();
        end
      end
      PH_STRLEN: begin
        pacc = {pacc[55:0], b};
        if (pcnt != 0) pcnt = pcnt - 1'b1;
        if (pcnt == 0) begin
          emit = 1'b1;
          kind = KIND_STRHDR;
          val  = {32'b0, pacc[31:0]};
          if (pacc[31:0] == 0) begin
            closed = close_done_levels();
          end else begin
            pstr = pacc[31:0];
            ps   = PH_STRBYTES;
          end
        end
      end
      PH_STRBYTES: begin
        emit = 1'b1;
        kind = KIND_STRBYTE;
        val  = {56'b0, b};
        if (pstr != 0) pstr = pstr - 1;
        if (pstr == 0) closed = close_done_levels();
      end
      PH_COUNT: begin
        pacc = {pacc[55:0], b};
        if (pcnt != 0) pcnt = pcnt - 1'b1;
        if (pcnt == 0) begin
          is_map = ({3'b0, ptag} == TAG_MAP);
          emit   = 1'b1;
          kind   = is_map ? KIND_MAPHDR : KIND_VECHDR;
          val    = {32'b0, pacc[31:0]};
          if (pacc[31:0] == 0) begin
            closed = close_done_levels();
          end else if (psp >= LEVELS) begin
            err = ERR_OVERFLOW;
          end else begin
            plev_left[psp] = pacc[31:0];
            plev_map[psp]  = is_map;
            psp++;
            ps = is_map ? PH_KEYLEN : PH_TAG;
          end
        end
      end
      PH_KEYLEN: begin
        emit = 1'b1;
        kind = KIND_KEYHDR;
        val  = {56'b0, b};
        if (b == 0) begin
          key_done = 1'b1;
        end else begin
          pstr = {24'b0, b};
          ps   = PH_KEYBYTES;
        end
      end
      PH_KEYBYTES: begin
        emit = 1'b1;
        kind = KIND_KEYBYTE;
        val  = {56'b0, b};
        if (pstr != 0) pstr = pstr - 1;
        if (pstr == 0) key_done = 1'b1;
      end
      default: begin
        reset_model();
      end
    endcase

    // key finished: the value follows, unless data ends on the last entry's key
    if (key_done) begin
      ps = PH_TAG;
      if (psp > 0) begin
        if (e && plev_left[psp - 1] == 1) closed = close_done_levels();
      end else begin
        psp = 0;
      end
    end

    if (err == ERR_NONE && e && !(ps == PH_TAG && psp == 0)) err = ERR_TRUNCATED;
    if (err != ERR_NONE) begin
      reset_model();
      if (!emit) begin
        emit   = 1'b1;
        kind   = KIND_UINT;
        val    = '0;
        closed = 0;
      end
    end

    tk.kind   = kind;
    tk.value  = val;
    tk.depth  = 5'(depth);
    tk.closed = 5'(closed);
    tk.err    = err;
    return emit;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    mismatches++;
  endtask

  function automatic void plain_row(input logic [7:0] b, input logic e);
    dir_rows.push_back('{data: b, last: e, known: 1'b0, tok: '0});
  endfunction

  function automatic void known_row(input logic [7:0] b, input logic e, input kind_t k,
                                    input logic [63:0] v, input logic [4:0] d,
                                    input logic [4:0] c, input err_t er);
    tok_t t;
    t = '{kind: k, value: v, depth: d, closed: c, err: er};
    dir_rows.push_back('{data: b, last: e, known: 1'b1, tok: t});
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    seq_q.push_back('{data: b, last: 1'b0});
  endfunction

  // big-endian field
  function automatic void push_be(input logic [63:0] v, input int nb);
    for (int i = nb - 1; i >= 0; i--) push_byte(v[i * 8 +: 8]);
  endfunction

  // one well-formed top-level value; cut_key ends the data on a final map key
  function automatic void gen_value(input int cap, input bit cut_key);
    int         lv_left [$];
    bit         lv_map [$];
    int         n;
    int         pick;
    int         len;
    int         sz;
    int         pat;
    logic [7:0] tag;
    bit         done;
    done = 1'b0;
    while (!done) begin
      // map entries open with a key
      if (lv_map.size() != 0 && lv_map[lv_map.size() - 1]) begin
        len = $urandom_range(0, 4);
        push_byte(8'(len));
        repeat (len) push_byte(8'($urandom_range(0, 255)));
        if (cut_key && lv_left[lv_left.size() - 1] == 1) begin
          seq_q[seq_q.size() - 1].last = 1'b1;
          return;
        end
      end
      pick = $urandom_range(0, 19);
      if (pick < 5 && lv_left.size() < cap) begin
        tag = (pick < 3) ? TAG_VEC : TAG_MAP;
        n   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
        push_byte(tag);
        push_be(64'(n), 4);
        if (n != 0) begin
          lv_left.push_back(n);
          lv_map.push_back(tag == TAG_MAP);
          continue;
        end
      end else begin
        tag = (pick < 18) ? 8'($urandom_range(0, 16)) : 8'($urandom_range(17, 255));
        push_byte(tag);
        if (tag <= TAG_UINT_LAST || (tag >= TAG_SINT_FIRST && tag <= TAG_SINT_LAST) ||
            tag == TAG_FLOAT) begin
          if (tag == TAG_FLOAT) sz = 8;
          else if (tag <= TAG_UINT_LAST) sz = 1 << tag;
          else sz = 1 << (tag - TAG_SINT_FIRST);
          // zeros, all ones, most negative, or random
          pat = $urandom_range(0, 3);
          for (int i = 0; i < sz; i++) begin
            case (pat)
              0: push_byte(8'h00);
              1: push_byte(8'hFF);
              2: push_byte((i == 0) ? 8'h80 : 8'h00);
              default: push_byte(8'($urandom_range(0, 255)));
            endcase
          end
        end else if (tag == TAG_BOOL) begin
          push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 1)));
        end else if (tag >= TAG_STR_FIRST && tag <= TAG_STR_LAST) begin
          sz  = 1 << (tag - TAG_STR_FIRST);
          len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
          push_be(64'(len), sz);
          repeat (len) push_byte(8'($urandom_range(0, 255)));
        end else if (tag == TAG_VEC || tag == TAG_MAP) begin
          // a container tag drawn here gets an empty container
          push_be(64'd0, 4);
        end
      end
      // element complete: close the levels that run out
      while (lv_left.size() != 0) begin
        lv_left[lv_left.size() - 1] = lv_left[lv_left.size() - 1] - 1;
        if (lv_left[lv_left.size() - 1] != 0) break;
        void'(lv_left.pop_back());
        void'(lv_map.pop_back());
      end
      done = (lv_left.size() == 0);
    end
  endfunction

  // drive one item and predict its token once taken
  task automatic send_byte(input logic [7:0] b, input logic e, input bit known,
                           input tok_t want);
    tok_t tk;
    bit   emitted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_data <= e;
    do @(posedge clk); while (in_stall);
    emitted = predict_token(b, e, tk);
    if (known) pending_tokens.push_back(want);
    else if (emitted) pending_tokens.push_back(tk);
    bytes_sent++;
  endtask

  // hold back until every pending token has come out
  task automatic drain_tokens();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 19);
    if (!idle_on) stall_left = 0;
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // compare each token taken with the oldest prediction
  always @(posedge clk) begin : token_check
    tok_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch("token with none pending, kind", 64'(out_token_kind), 64'd0);
      end else begin
        want = pending_tokens.pop_front();
        if (out_token_kind != want.kind)
          report_mismatch("token_kind", 64'(out_token_kind), 64'(want.kind));
        if (out_token_value != want.value)
          report_mismatch("token_value", out_token_value, want.value);
        if (out_nesting_depth != want.depth)
          report_mismatch("nesting_depth", 64'(out_nesting_depth), 64'(want.depth));
        if (out_closed_levels != want.closed)
          report_mismatch("closed_levels", 64'(out_closed_levels), 64'(want.closed));
        if (out_error_code != want.err)
          report_mismatch("error_code", 64'(out_error_code), 64'(want.err));
        tokens_seen++;
        if (want.err == ERR_TRUNCATED) trunc_seen++;
        if (want.err == ERR_OVERFLOW) overflow_seen++;
        if (int'(want.closed) > deepest_close) deepest_close = int'(want.closed);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d tokens pending", pending_tokens.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int         seq_no;
    int         shape;
    int         idx;
    int         rand_sent;
    bit         paused;
    logic [7:0] tag;
    seq_no    = 0;
    rand_sent = 0;
    paused    = 1'b0;
    reset_model();
    for (int i = 0; i < LEVELS; i++) begin
      plev_left[i] = '0;
      plev_map[i]  = 1'b0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, several element types, empty cases, final key, truncation
    known_row(8'hFF, 1'b0, KIND_UNKNOWN, 64'd255, 5'd0, 5'd0, ERR_NONE);
    known_row(TAG_LIMIT, 1'b0, KIND_UNKNOWN, 64'd17, 5'd0, 5'd0, ERR_NONE);
    known_row(TAG_NULL, 1'b0, KIND_NULL, 64'd0, 5'd0, 5'd0, ERR_NONE);
    known_row(TAG_EXT, 1'b0, KIND_EXT, 64'd0, 5'd0, 5'd0, ERR_NONE);
    plain_row(TAG_SINT_FIRST, 1'b0);
    known_row(8'h80, 1'b0, KIND_SINT, 64'hFFFF_FFFF_FFFF_FF80, 5'd0, 5'd0, ERR_NONE);
    plain_row(8'h00, 1'b0);
    known_row(8'hFF, 1'b0, KIND_UINT, 64'd255, 5'd0, 5'd0, ERR_NONE);
    plain_row(TAG_BOOL, 1'b0);
    known_row(8'h01, 1'b0, KIND_BOOL, 64'd1, 5'd0, 5'd0, ERR_NONE);
    plain_row(TAG_STR_FIRST, 1'b0);
    known_row(8'h00, 1'b0, KIND_STRHDR, 64'd0, 5'd0, 5'd0, ERR_NONE);
    plain_row(TAG_VEC, 1'b0);
    repeat (3) plain_row(8'h00, 1'b0);
    known_row(8'h00, 1'b0, KIND_VECHDR, 64'd0, 5'd0, 5'd0, ERR_NONE);
    plain_row(TAG_MAP, 1'b0);
    repeat (3) plain_row(8'h00, 1'b0);
    known_row(8'h02, 1'b0, KIND_MAPHDR, 64'd2, 5'd0, 5'd0, ERR_NONE);
    known_row(8'h00, 1'b0, KIND_KEYHDR, 64'd0, 5'd1, 5'd0, ERR_NONE);
    plain_row(TAG_NULL, 1'b0);
    plain_row(8'h01, 1'b0);
    known_row(8'h41, 1'b1, KIND_KEYBYTE, 64'h41, 5'd1, 5'd1, ERR_NONE);
    known_row(TAG_UINT_LAST, 1'b1, KIND_UINT, 64'd0, 5'd0, 5'd0, ERR_TRUNCATED);
    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].known, dir_rows[i].tok);
    drain_tokens();

    // random sequences: mostly well-formed values, some deep nests, cuts and noise
    while (rand_sent < RAND_BYTES) begin
      idle_on = (rand_sent < RAND_BYTES - 100) && ($urandom_range(0, 3) != 0);
      if (!paused && rand_sent >= RAND_BYTES / 2) begin
        paused = 1'b1;
        drain_tokens();
      end
      seq_q.delete();
      shape = (seq_no % 20 == 5) ? 0 : $urandom_range(1, 99);
      if (shape == 0) begin
        // full stack, then a scalar, an empty or an overflowing container
        for (int i = 0; i < LEVELS; i++) begin
          tag = $urandom_range(0, 1) ? TAG_MAP : TAG_VEC;
          push_byte(tag);
          push_be(64'd1, 4);
          if (tag == TAG_MAP) push_byte(8'h00);
        end
        gen_value((seq_no / 20) % 2, 1'b0);
      end else if (shape < 10) begin
        repeat ($urandom_range(1, 12))
          seq_q.push_back('{data: 8'($urandom_range(0, 255)),
                            last: ($urandom_range(0, 7) == 0)});
      end else begin
        gen_value($urandom_range(1, 4), shape < 30);
      end
      if (shape >= 85) begin
        idx = $urandom_range(0, seq_q.size() - 1);
        seq_q[idx].last = 1'b1;
        while (seq_q.size() > idx + 1) void'(seq_q.pop_back());
      end else if (shape >= 10 && $urandom_range(0, 3) == 0) begin
        seq_q[seq_q.size() - 1].last = 1'b1;
      end
      foreach (seq_q[i]) send_byte(seq_q[i].data, seq_q[i].last, 1'b0, '0);
      rand_sent += seq_q.size();
      seq_no++;
    end

    idle_on = 1'b0;
    drain_tokens();
    repeat (10) @(posedge clk);

    $display("sent %0d bytes in %0d random sequences, checked %0d tokens", bytes_sent, seq_no,
             tokens_seen);
    $display("truncations %0d, overflows %0d, most levels closed by one token %0d",
             trunc_seen, overflow_seen, deepest_close);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d tokens never seen", mismatches, pending_tokens.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
